// File: src/tbhr_pkg.sv
package tbhr_pkg;

  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int COORD_W = 24;
  localparam int TIME_W = 31;
  localparam int FRAC_W = 16;
  localparam int NUM_COORDS = 9;
  localparam int RESET_SPACING = 50;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [TIME_W-1:0] stamp_t;

  // Coordinates 0..2 hold the origin, 3..5 the min corner, 6..8 the max corner.
  typedef struct packed {
    stamp_t t;
    coord_t [NUM_COORDS-1:0] c;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_NEWER,
    CELL_FROM_OLDER
  } cell_op_t;

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_RESET = 2'd1,
    CMD_SHIFT = 2'd2,
    CMD_UNSHIFT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_UNCHANGED = 3'd0,
    ST_INTERP = 3'd1,
    ST_OLDEST = 3'd2,
    ST_RESTORED = 3'd3,
    ST_WRITTEN = 3'd4
  } status_t;

endpackage

// File: src/tbhr_cell.sv
module tbhr_cell
  import tbhr_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic     clk,
  input  cell_op_t op,
  input  entry_t   load_d,
  input  entry_t   newer_d,
  input  entry_t   older_d,
  output entry_t   q
);

  // Age of this slot when the history is refilled: newest at the head.
  localparam stamp_t AGE = TIME_W'(RESET_SPACING * IDX);

  entry_t loaded;

  always_comb begin
    loaded = load_d;
    loaded.t = (load_d.t >= AGE) ? load_d.t - AGE : '0;
  end

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_HOLD:       q <= q;
      CELL_LOAD:       q <= loaded;
      CELL_FROM_NEWER: q <= newer_d;
      CELL_FROM_OLDER: q <= older_d;
      default:         q <= q;
    endcase
  end

endmodule

// File: src/tbhr_div.sv
module tbhr_div
  import tbhr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  stamp_t            num,
  input  stamp_t            den,
  output logic              done,
  output logic [FRAC_W-1:0] quo
);

  localparam int CNT_W = $clog2(FRAC_W + 1);

  // The numerator is below the divisor, so every quotient bit is a fraction bit.
  logic [TIME_W:0]  rem;
  logic [TIME_W:0]  rem2;
  stamp_t           den_r;
  logic [CNT_W-1:0] cnt;
  logic             run;

  assign rem2 = {rem[TIME_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        rem <= {1'b0, num};
        den_r <= den;
      end else if (run) begin
        if (rem2 >= {1'b0, den_r}) begin
          rem <= rem2 - {1'b0, den_r};
          quo <= {quo[FRAC_W-2:0], 1'b1};
        end else begin
          rem <= rem2;
          quo <= {quo[FRAC_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(FRAC_W - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/timestamped_box_history_rewind_core.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------------------
// request  | start, busy        | command, now_time, query_time, cur_*, box_min_*,
//          |                    | box_max_*
// result   | done (one cycle)   | status, out_x/y/z, out_min_x/y/z, out_max_x/y/z
//
// Store, reset history, unshift and a shift whose head entry is already old enough
// never leave idle: done is high in the cycle after start and busy stays low.
// Any other shift turns the cell chain once, back into place; if every entry is
// newer than the query, the oldest one is the result word. An interpolating shift
// then runs the fraction divider, its hand-off and the blend pipeline first.
// Reset is synchronous and clears control state; the history cells hold nothing
// valid until written. The receiver cannot stall: each result word is shown once.
module timestamped_box_history_rewind_core
  import tbhr_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  input  logic [1:0]    command,
  input  logic [30:0]   now_time,
  input  logic [30:0]   query_time,
  input  logic signed [23:0] cur_x,
  input  logic signed [23:0] cur_y,
  input  logic signed [23:0] cur_z,
  input  logic signed [23:0] box_min_x,
  input  logic signed [23:0] box_min_y,
  input  logic signed [23:0] box_min_z,
  input  logic signed [23:0] box_max_x,
  input  logic signed [23:0] box_max_y,
  input  logic signed [23:0] box_max_z,
  output logic [2:0]    status,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic signed [23:0] out_z,
  output logic signed [23:0] out_min_x,
  output logic signed [23:0] out_min_y,
  output logic signed [23:0] out_min_z,
  output logic signed [23:0] out_max_x,
  output logic signed [23:0] out_max_y,
  output logic signed [23:0] out_max_z
);

  localparam int CNT_W = (HISTORY_DEPTH > 2) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int LCNT_W = 4;
  localparam int PROD_W = COORD_W + 1 + FRAC_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_LERP
  } state_t;

  // Truncates a fixed point coordinate toward zero to whole units.
  function automatic coord_t trunc_whole(coord_t v);
    coord_t mag;
    begin
      mag = -v;
      if (v >= 0) trunc_whole = v & ~coord_t'(15);
      else trunc_whole = -(mag & ~coord_t'(15));
    end
  endfunction

  state_t state;
  logic [CNT_W-1:0] cnt;
  logic [LCNT_W-1:0] lcnt;
  logic found;
  logic gap_ok;
  stamp_t query_l;
  stamp_t saved_stamp;
  coord_t [NUM_COORDS-1:0] saved_box;
  entry_t live_e;
  entry_t live_l;
  entry_t store_e;
  entry_t load_e;
  entry_t prev_e;
  entry_t old_e;
  entry_t new_e;
  coord_t [NUM_COORDS-1:0] res;
  cell_op_t op_head;
  cell_op_t op_rest;
  entry_t cq [HISTORY_DEPTH];

  logic div_start;
  logic div_done;
  logic [FRAC_W-1:0] div_quo;
  logic [FRAC_W-1:0] frac;

  logic signed [COORD_W:0] diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] rounded;
  logic [LCNT_W-1:0] idx1;
  logic [LCNT_W-1:0] idx2;
  logic v1;
  logic v2;
  logic hit;
  logic head_hit;
  logic accept;

  assign live_e.t = now_time;
  assign live_e.c = {box_max_z, box_max_y, box_max_x, box_min_z, box_min_y, box_min_x,
                     cur_z, cur_y, cur_x};

  always_comb begin
    store_e = live_e;
    for (int c = 0; c < 3; c++) store_e.c[c] = trunc_whole(live_e.c[c]);
  end

  assign load_e = (cmd_t'(command) == CMD_STORE) ? store_e : live_e;
  assign accept = start && !busy;
  assign busy = (state != S_IDLE);
  assign head_hit = (cq[0].t <= query_time);
  assign hit = !found && (cq[0].t <= query_l);

  // The chain rotates toward the head during a scan, so the head cell shows
  // successively older entries and is back in place after a full turn.
  always_comb begin
    op_head = CELL_HOLD;
    op_rest = CELL_HOLD;
    if (state == S_IDLE && accept) begin
      unique case (cmd_t'(command))
        CMD_STORE: begin
          op_head = CELL_LOAD;
          op_rest = CELL_FROM_NEWER;
        end
        CMD_RESET: begin
          op_head = CELL_LOAD;
          op_rest = CELL_LOAD;
        end
        CMD_SHIFT: begin
          if (!head_hit) begin
            op_head = CELL_FROM_OLDER;
            op_rest = CELL_FROM_OLDER;
          end
        end
        CMD_UNSHIFT: ;
        default: ;
      endcase
    end else if (state == S_SCAN) begin
      op_head = CELL_FROM_OLDER;
      op_rest = CELL_FROM_OLDER;
    end
  end

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    localparam int OLDER = (i + 1) % HISTORY_DEPTH;
    entry_t newer_d;
    if (i == 0) begin : g_head
      assign newer_d = '0;
    end else begin : g_body
      assign newer_d = cq[i-1];
    end
    tbhr_cell #(.IDX(i)) u_cell (
      .clk(clk),
      .op((i == 0) ? op_head : op_rest),
      .load_d(load_e),
      .newer_d(newer_d),
      .older_d(cq[OLDER]),
      .q(cq[i])
    );
  end

  assign div_start = (state == S_SCAN) && (cnt == CNT_W'(HISTORY_DEPTH - 1))
                     && (found || hit);

  tbhr_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num(query_l - (hit ? cq[0].t : old_e.t)),
    .den((hit ? prev_e.t : new_e.t) - (hit ? cq[0].t : old_e.t)),
    .done(div_done),
    .quo(div_quo)
  );

  assign rounded = prod_r + PROD_W'(32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      cnt <= '0;
      lcnt <= '0;
      found <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      saved_stamp <= '0;
      saved_box <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            live_l <= live_e;
            query_l <= query_time;
            unique case (cmd_t'(command))
              CMD_STORE, CMD_RESET: begin
                status <= ST_WRITTEN;
                res <= '0;
                done <= 1'b1;
              end
              CMD_SHIFT: begin
                if (head_hit) begin
                  status <= ST_UNCHANGED;
                  res <= live_e.c;
                  done <= 1'b1;
                end else begin
                  prev_e <= cq[0];
                  cnt <= CNT_W'(1);
                  found <= 1'b0;
                  state <= S_SCAN;
                end
              end
              CMD_UNSHIFT: begin
                if (saved_stamp == now_time) begin
                  status <= ST_RESTORED;
                  res <= saved_box;
                  saved_stamp <= '0;
                end else begin
                  status <= ST_UNCHANGED;
                  res <= live_e.c;
                end
                done <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          prev_e <= cq[0];
          cnt <= cnt + 1'b1;
          if (hit) begin
            old_e <= cq[0];
            new_e <= prev_e;
            found <= 1'b1;
          end
          if (cnt == CNT_W'(HISTORY_DEPTH - 1)) begin
            if (saved_stamp != live_l.t) begin
              saved_box <= live_l.c;
              saved_stamp <= live_l.t;
            end
            if (found || hit) begin
              gap_ok <= hit ? (prev_e.t > cq[0].t) : (new_e.t > old_e.t);
              state <= S_DIV;
            end else begin
              status <= ST_OLDEST;
              res <= cq[0].c;
              done <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            frac <= gap_ok ? div_quo : '0;
            lcnt <= '0;
            v1 <= 1'b0;
            v2 <= 1'b0;
            state <= S_LERP;
          end
        end
        S_LERP: begin
          // Three stage pipeline: difference, product, rounded sum.
          lcnt <= lcnt + 1'b1;
          v1 <= (lcnt < LCNT_W'(NUM_COORDS));
          idx1 <= lcnt;
          diff_r <= {new_e.c[lcnt][COORD_W-1], new_e.c[lcnt]}
                    - {old_e.c[lcnt][COORD_W-1], old_e.c[lcnt]};
          v2 <= v1;
          idx2 <= idx1;
          prod_r <= PROD_W'(diff_r * $signed({1'b0, frac}));
          if (v2) begin
            res[idx2] <= old_e.c[idx2] + COORD_W'(rounded >>> FRAC_W);
          end
          if (lcnt == LCNT_W'(NUM_COORDS + 1)) begin
            status <= ST_INTERP;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign out_min_x = res[3];
  assign out_min_y = res[4];
  assign out_min_z = res[5];
  assign out_max_x = res[6];
  assign out_max_y = res[7];
  assign out_max_z = res[8];

endmodule

// File: tb/timestamped_box_history_rewind_core_tb.sv
module timestamped_box_history_rewind_core_tb;
  import tbhr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 80;
  localparam int RANDOM_WORDS = 400;
  localparam longint TIME_MAX = 64'h7FFF_FFFF;

  // One request word as it is presented on the input ports.
  typedef struct packed {
    cmd_t cmd;
    stamp_t now;
    stamp_t query;
    coord_t [NUM_COORDS-1:0] box;
  } request_t;

  // One result word: status plus the nine box coordinates.
  typedef struct packed {
    logic [2:0] status;
    coord_t [NUM_COORDS-1:0] box;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  request_t drive_word = '0;
  logic [2:0] status;
  coord_t out_x, out_y, out_z, out_min_x, out_min_y, out_min_z;
  coord_t out_max_x, out_max_y, out_max_z;

  request_t pending_words[$];
  answer_t expected_answers[$];
  int errors = 0;
  int accepted_count = 0;
  int answered_count = 0;
  int status_seen[8];
  int idle_cycles = 0;
  int gap_left = 0;
  bit no_idle = 1'b0;

  // The box at a given cycle is the live origin, min corner and max corner in that order.
  timestamped_box_history_rewind_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .command(drive_word.cmd), .now_time(drive_word.now), .query_time(drive_word.query),
    .cur_x(drive_word.box[0]), .cur_y(drive_word.box[1]), .cur_z(drive_word.box[2]),
    .box_min_x(drive_word.box[3]), .box_min_y(drive_word.box[4]),
    .box_min_z(drive_word.box[5]), .box_max_x(drive_word.box[6]),
    .box_max_y(drive_word.box[7]), .box_max_z(drive_word.box[8]),
    .status(status), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_min_x(out_min_x), .out_min_y(out_min_y), .out_min_z(out_min_z),
    .out_max_x(out_max_x), .out_max_y(out_max_y), .out_max_z(out_max_z)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: the history ring, the head pointer and the saved live box.
  // ---------------------------------------------------------------------------
  stamp_t ring_time[DEPTH];
  int ring_box[DEPTH][NUM_COORDS];
  int head_slot = DEPTH - 1;
  stamp_t saved_stamp = '0;
  int saved_box[NUM_COORDS] = '{default: 0};

  // Origins stored by a store command are cut toward zero to whole units.
  function automatic int cut_to_whole(int v);
    if (v >= 0) return v & ~15;
    return -((-v) & ~15);
  endfunction

  // Rounded linear blend: old + floor(((new - old) * frac + half) / 2^16).
  function automatic int blend(int older, int newer, int frac);
    longint p;
    p = longint'(newer - older) * longint'(frac) + 64'sd32768;
    return older + int'(p >>> 16);
  endfunction

  // Applies one request word to the history and returns the result word it causes.
  function automatic answer_t rewind_history(request_t w);
    answer_t a;
    int live[NUM_COORDS];
    int res[NUM_COORDS];
    int j, k, frac;
    longint t;
    for (int i = 0; i < NUM_COORDS; i++) begin
      live[i] = int'(w.box[i]);
      res[i] = live[i];
    end
    a.status = ST_UNCHANGED;
    case (w.cmd)
      CMD_STORE: begin
        head_slot = (head_slot + 1 >= DEPTH) ? 0 : head_slot + 1;
        ring_time[head_slot] = w.now;
        for (int i = 0; i < NUM_COORDS; i++)
          ring_box[head_slot][i] = (i < 3) ? cut_to_whole(live[i]) : live[i];
        a.status = ST_WRITTEN;
      end
      CMD_RESET: begin
        // Newest entry in the last slot, each older one 50 ms earlier, floored at zero.
        t = longint'(w.now);
        head_slot = DEPTH - 1;
        for (int s = DEPTH - 1; s >= 0; s--) begin
          ring_time[s] = stamp_t'(t);
          for (int i = 0; i < NUM_COORDS; i++) ring_box[s][i] = live[i];
          t = (t >= RESET_SPACING) ? t - RESET_SPACING : 0;
        end
        a.status = ST_WRITTEN;
      end
      CMD_SHIFT: begin
        // Walk back from the head until an entry is no newer than the query.
        j = head_slot;
        k = head_slot;
        do begin
          if (ring_time[j] <= w.query) break;
          k = j;
          j = (j == 0) ? DEPTH - 1 : j - 1;
        end while (j != head_slot);
        if (j != k) begin
          if (saved_stamp != w.now) begin
            saved_box = live;
            saved_stamp = w.now;
          end
          if (j != head_slot) begin
            frac = 0;
            if (ring_time[k] > ring_time[j] && w.query >= ring_time[j]) begin
              t = (longint'(w.query - ring_time[j]) << 16) /
                  longint'(ring_time[k] - ring_time[j]);
              frac = (t > 65535) ? 65535 : int'(t);
            end
            for (int i = 0; i < NUM_COORDS; i++)
              res[i] = blend(ring_box[j][i], ring_box[k][i], frac);
            a.status = ST_INTERP;
          end else begin
            // Every entry is newer than the query: answer with the oldest one.
            for (int i = 0; i < NUM_COORDS; i++) res[i] = ring_box[k][i];
            a.status = ST_OLDEST;
          end
        end
      end
      default: begin
        if (saved_stamp == w.now) begin
          res = saved_box;
          saved_stamp = '0;
          a.status = ST_RESTORED;
        end
      end
    endcase
    for (int i = 0; i < NUM_COORDS; i++)
      a.box[i] = (a.status == ST_WRITTEN) ? '0 : coord_t'(res[i]);
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued words, holding start until the block takes each one.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    request_t w;
    bit taken;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        expected_answers.push_back(rewind_history(drive_word));
        accepted_count++;
      end
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          drive_word <= w;
          start <= 1'b1;
          if ($urandom_range(0, 99) < 4) no_idle = !no_idle;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every done cycle carries one result word, checked in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && done) begin
      got.status = status;
      got.box = {out_max_z, out_max_y, out_max_x, out_min_z, out_min_y, out_min_x,
                 out_z, out_y, out_x};
      answered_count++;
      if (expected_answers.size() == 0) begin
        $display("%0t: result word with none expected: status %0d", $time, got.status);
        errors++;
      end else begin
        want = expected_answers.pop_front();
        status_seen[want.status]++;
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
          errors++;
        end
        for (int i = 0; i < NUM_COORDS; i++)
          if (got.box[i] !== want.box[i]) begin
            $display("%0t: coordinate %0d expected %0d, actual %0d", $time, i,
                     want.box[i], got.box[i]);
            errors++;
          end
      end
    end
  end

  // Watchdog: ends the run when neither side moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d quiet cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation.
  // ---------------------------------------------------------------------------
  function automatic coord_t any_coord();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 24'sh800000;
    if (r == 1) return 24'sh7FFFFF;
    if (r < 8) return coord_t'($urandom_range(0, 4000)) - 24'sd2000;
    return coord_t'($urandom);
  endfunction

  function automatic void queue_word(cmd_t c, longint now, longint query,
                                     coord_t [NUM_COORDS-1:0] box);
    request_t w;
    w.cmd = c;
    w.now = stamp_t'(now);
    w.query = stamp_t'(query);
    w.box = box;
    pending_words.push_back(w);
  endfunction

  function automatic void queue_random(cmd_t c, longint now, longint query);
    coord_t [NUM_COORDS-1:0] box;
    for (int i = 0; i < NUM_COORDS; i++) box[i] = any_coord();
    queue_word(c, now, query, box);
  endfunction

  initial begin
    coord_t [NUM_COORDS-1:0] low_box, high_box;
    longint frame, q;
    int words, r;
    for (int i = 0; i < NUM_COORDS; i++) begin
      low_box[i] = 24'sh800000;
      high_box[i] = 24'sh7FFFFF;
    end

    // Directed part. The history is always seeded by a reset first, so no shift
    // ever reads a slot that was never written.
    queue_word(CMD_RESET, 20, 0, high_box);          // older times floor at zero
    queue_random(CMD_SHIFT, 20, 0);                  // brackets the zero entries
    queue_random(CMD_SHIFT, 20, 100);                // head already old enough
    queue_random(CMD_UNSHIFT, 20, 0);                // restore the saved box
    queue_random(CMD_UNSHIFT, 20, 0);                // mark cleared: unchanged
    queue_random(CMD_UNSHIFT, 0, 0);                 // saved stamp zero, now zero
    queue_word(CMD_STORE, 40, 0, low_box);           // negative origin cut
    queue_word(CMD_STORE, 60, 0, high_box);          // positive origin cut
    queue_random(CMD_SHIFT, 61, 50);                 // blend between the extremes
    queue_random(CMD_SHIFT, 61, 59);
    queue_random(CMD_UNSHIFT, 61, TIME_MAX);
    queue_word(CMD_RESET, TIME_MAX, TIME_MAX, low_box);
    queue_random(CMD_SHIFT, TIME_MAX, 0);            // every entry newer: oldest
    queue_random(CMD_SHIFT, TIME_MAX, TIME_MAX - 75);
    queue_random(CMD_UNSHIFT, TIME_MAX, 0);
    queue_random(CMD_STORE, TIME_MAX, TIME_MAX);
    queue_random(CMD_SHIFT, 7, TIME_MAX - 1);
    queue_random(CMD_UNSHIFT, 8, 0);

    // Random part: mostly frames of store, shift and unshift with rising times,
    // the rest resets, time jumps and stray commands.
    frame = 1000;
    queue_random(CMD_RESET, frame, 0);
    words = 0;
    while (words < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      frame += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 40);
      if (r < 4 || frame > TIME_MAX) begin
        frame = (r < 2) ? TIME_MAX - $urandom_range(0, 2000) : $urandom_range(0, 3000);
        queue_random(CMD_RESET, frame, $urandom);
        words++;
      end else if (r < 80) begin
        queue_random(CMD_STORE, frame, $urandom);
        q = frame - $urandom_range(0, ($urandom_range(0, 3) == 0) ? 1500 : 500);
        if (q < 0) q = 0;
        queue_random(CMD_SHIFT, frame, q);
        words += 2;
        if ($urandom_range(0, 2) == 0) begin
          queue_random(CMD_SHIFT, frame, q + $urandom_range(0, 60));
          words++;
        end
        queue_random(CMD_UNSHIFT, ($urandom_range(0, 5) == 0) ? frame + 1 : frame, $urandom);
        words++;
      end else begin
        queue_random(cmd_t'($urandom_range(0, 3)), ($urandom_range(0, 1) == 0) ?
                     longint'($urandom) & TIME_MAX : frame, longint'($urandom) & TIME_MAX);
        words++;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && !start && expected_answers.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d result words for %0d accepted words.", answered_count,
             accepted_count);
    $display("Status counts: unchanged %0d, blended %0d, oldest %0d, restored %0d, written %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
